// ===== rtl/core/itp_pkg.sv =====
`default_nettype none
package itp_pkg;

    typedef enum logic [3:0] {
        PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_FRAC, PH_OFFH, PH_OFFM, PH_DEAD
    } phase_t;

    typedef enum logic [1:0] {ZU_NONE, ZU_UPPER, ZU_LOWER} zulu_t;

    // parsed fields of one finished timestamp
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [19:0] frac;
        logic [2:0]  frac_digits;
        logic        off_neg;
        logic [6:0]  off_hours;
        logic [6:0]  off_mins;
    } fields_t;

    typedef enum logic [2:0] {
        CV_IDLE, CV_S1, CV_S2, CV_S3, CV_S4, CV_S5, CV_S6, CV_DONE
    } conv_t;

    localparam int QDEPTH = 2;

endpackage
`default_nettype wire

// ===== rtl/core/itp_front.sv =====
`default_nettype none
module itp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      char_code,
    input  wire logic            last_char,
    output logic                 f_valid,
    input  wire logic            f_ready,
    output itp_pkg::fields_t     f_data
);
    import itp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic        ok_reg, ok_next;
    zulu_t       zu_reg, zu_next;
    fields_t     fd_reg, fd_next;
    fields_t     q_reg [QDEPTH];
    logic        qw_reg, qr_reg;
    logic [1:0]  qc_reg;
    logic        push, pop;

    assign in_ready = (qc_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready && last_char;
    assign f_valid  = (qc_reg != 2'd0);
    assign f_data   = q_reg[qr_reg];
    assign pop      = f_valid && f_ready;

    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [6:0] acc2(input logic [6:0] v, input logic [7:0] c);
        return 7'(v * 7'd10 + 7'(c - 8'h30));
    endfunction

    // one parser step; Z applies as "+00:00" in one shot
    always_comb
    begin
        logic [7:0] c;
        logic       d, sg, ok;
        logic       zap;
        c = char_code;
        d = is_dig(c);
        sg = (c == 8'h2B) || (c == 8'h2D);
        phase_next = phase_reg;
        pos_next = pos_reg;
        ok_next = ok_reg;
        zu_next = zu_reg;
        fd_next = fd_reg;
        ok = 1'b1;
        zap = 1'b0;
        if (zu_reg == ZU_NONE)
        begin
            if (c == 8'h5A || c == 8'h7A)
            begin
                zu_next = (c == 8'h5A) ? ZU_UPPER : ZU_LOWER;
                zap = 1'b1;
            end
        end
        else if (zu_reg == ZU_LOWER && c == 8'h5A)
        begin
            ok_next = 1'b0;
        end
        if (zu_reg == ZU_NONE && ok_reg)
        begin
            if (zap)
            begin
                // Z must follow whole minutes, seconds or a fraction; it sets offset +00:00
                if ((phase_reg == PH_MIN || phase_reg == PH_SEC) && pos_reg == 3'd2)
                    ;
                else if (phase_reg == PH_FRAC)
                    ;
                else
                    ok = 1'b0;
                fd_next.off_neg = 1'b0;
                fd_next.off_hours = '0;
                fd_next.off_mins = '0;
                phase_next = PH_OFFM;
                pos_next = 3'd2;
            end
            else
            begin
                unique case (phase_reg)
                    PH_YEAR:
                        if (pos_reg < 3'd4 && d)
                        begin
                            fd_next.year = 14'(fd_reg.year * 14'd10 + 14'(c - 8'h30));
                            pos_next = pos_reg + 3'd1;
                        end
                        else if (pos_reg == 3'd4 && c == 8'h2D)
                        begin
                            phase_next = PH_MONTH; pos_next = '0;
                        end
                        else ok = 1'b0;
                    PH_MONTH:
                        if (pos_reg < 3'd2 && d)
                        begin
                            fd_next.month = acc2(fd_reg.month, c); pos_next = pos_reg + 3'd1;
                        end
                        else if (pos_reg == 3'd2 && c == 8'h2D)
                        begin
                            phase_next = PH_DAY; pos_next = '0;
                        end
                        else ok = 1'b0;
                    PH_DAY:
                        if (pos_reg < 3'd2 && d)
                        begin
                            fd_next.day = acc2(fd_reg.day, c); pos_next = pos_reg + 3'd1;
                        end
                        else if (pos_reg == 3'd2 && (c == 8'h54 || c == 8'h20))
                        begin
                            phase_next = PH_HOUR; pos_next = '0;
                        end
                        else ok = 1'b0;
                    PH_HOUR:
                        if (pos_reg < 3'd2 && d)
                        begin
                            fd_next.hour = acc2(fd_reg.hour, c); pos_next = pos_reg + 3'd1;
                        end
                        else if (pos_reg == 3'd2 && c == 8'h3A)
                        begin
                            phase_next = PH_MIN; pos_next = '0;
                        end
                        else ok = 1'b0;
                    PH_MIN, PH_SEC:
                        if (pos_reg < 3'd2 && d)
                        begin
                            if (phase_reg == PH_MIN) fd_next.minute = acc2(fd_reg.minute, c);
                            else fd_next.second = acc2(fd_reg.second, c);
                            pos_next = pos_reg + 3'd1;
                        end
                        else if (pos_reg != 3'd2) ok = 1'b0;
                        else if (phase_reg == PH_MIN && c == 8'h3A)
                        begin
                            phase_next = PH_SEC; pos_next = '0;
                        end
                        else if (c == 8'h2E)
                        begin
                            phase_next = PH_FRAC; pos_next = '0;
                        end
                        else if (sg)
                        begin
                            fd_next.off_neg = (c == 8'h2D); phase_next = PH_OFFH; pos_next = '0;
                        end
                        else ok = 1'b0;
                    PH_FRAC:
                        if (d && fd_reg.frac_digits < 3'd6)
                        begin
                            fd_next.frac = 20'(fd_reg.frac * 20'd10 + 20'(c - 8'h30));
                            fd_next.frac_digits = fd_reg.frac_digits + 3'd1;
                        end
                        else if (sg)
                        begin
                            fd_next.off_neg = (c == 8'h2D); phase_next = PH_OFFH; pos_next = '0;
                        end
                        else ok = 1'b0;
                    PH_OFFH:
                        if (pos_reg < 3'd2 && d)
                        begin
                            fd_next.off_hours = acc2(fd_reg.off_hours, c);
                            pos_next = pos_reg + 3'd1;
                        end
                        else if (pos_reg == 3'd2 && c == 8'h3A)
                        begin
                            phase_next = PH_OFFM; pos_next = '0;
                        end
                        else ok = 1'b0;
                    PH_OFFM:
                        if (pos_reg < 3'd2 && d)
                        begin
                            fd_next.off_mins = acc2(fd_reg.off_mins, c);
                            pos_next = pos_reg + 3'd1;
                        end
                        else ok = 1'b0;
                    default: ok = 1'b0;
                endcase
            end
            if (!ok) ok_next = 1'b0;
        end
        // end-of-text check
        fd_next.ok = ok_next
            && ((((phase_next == PH_DAY) || (phase_next == PH_MIN) || (phase_next == PH_SEC)
                 || (phase_next == PH_OFFM)) && pos_next == 3'd2) || phase_next == PH_FRAC)
            && fd_next.month >= 7'd1 && fd_next.month <= 7'd12
            && fd_next.day >= 7'd1 && fd_next.day <= 7'd31;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_YEAR;
            pos_reg <= '0;
            ok_reg <= 1'b1;
            zu_reg <= ZU_NONE;
            fd_reg <= '0;
            qw_reg <= 1'b0;
            qr_reg <= 1'b0;
            qc_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (last_char)
                begin
                    phase_reg <= PH_YEAR;
                    pos_reg <= '0;
                    ok_reg <= 1'b1;
                    zu_reg <= ZU_NONE;
                    fd_reg <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    pos_reg <= pos_next;
                    ok_reg <= ok_next;
                    zu_reg <= zu_next;
                    fd_reg <= fd_next;
                end
            end
            if (push) qw_reg <= ~qw_reg;
            if (pop) qr_reg <= ~qr_reg;
            qc_reg <= 2'(qc_reg + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[qw_reg] <= fd_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/itp_back.sv =====
`default_nettype none
module itp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               f_valid,
    output logic                    f_ready,
    input  wire itp_pkg::fields_t   f_data,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [63:0]             m_tdata,
    output logic                    m_tuser
);
    import itp_pkg::*;

    conv_t               st_reg, st_next;
    fields_t             fd_reg;
    logic signed [14:0]  y_reg;
    logic signed [5:0]   era_reg;
    logic        [8:0]   yoe_reg;
    logic        [8:0]   doy_reg;
    logic signed [22:0]  base_reg;
    logic signed [22:0]  days_reg;
    logic signed [40:0]  secs_reg;
    logic signed [58:0]  us_reg;
    logic        [19:0]  frac_reg;
    logic signed [20:0]  lo_reg;

    assign f_ready  = (st_reg == CV_IDLE);
    assign m_tvalid = (st_reg == CV_DONE);
    assign m_tdata  = {5'd0, us_reg};
    assign m_tuser  = fd_reg.ok;

    // days before the first of each month, counted from March 1
    function automatic logic [8:0] month_start(input logic [6:0] m);
        logic [8:0] s;
        unique case (m)
            7'd3:    s = 9'd0;
            7'd4:    s = 9'd31;
            7'd5:    s = 9'd61;
            7'd6:    s = 9'd92;
            7'd7:    s = 9'd122;
            7'd8:    s = 9'd153;
            7'd9:    s = 9'd184;
            7'd10:   s = 9'd214;
            7'd11:   s = 9'd245;
            7'd12:   s = 9'd275;
            7'd1:    s = 9'd306;
            7'd2:    s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            CV_IDLE: if (f_valid) st_next = CV_S1;
            CV_S1:   st_next = CV_S2;
            CV_S2:   st_next = CV_S3;
            CV_S3:   st_next = CV_S4;
            CV_S4:   st_next = CV_S5;
            CV_S5:   st_next = CV_S6;
            CV_S6:   st_next = CV_DONE;
            CV_DONE: if (m_tready) st_next = CV_IDLE;
            default: st_next = CV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) st_reg <= CV_IDLE;
        else st_reg <= st_next;
    end

    // year is 0..9999, so y drops below zero only for January or February of year 0
    always_ff @(posedge clk)
    begin
        logic        [19:0] fr;
        logic signed [20:0] hms;
        logic signed [20:0] off;
        logic        [27:0] q;
        logic        [17:0] doe;
        logic        [1:0]  cent;
        unique case (st_reg)
            CV_IDLE:
                if (f_valid) fd_reg <= f_data;
            CV_S1:
            begin
                y_reg <= signed'({1'b0, fd_reg.year})
                         - ((fd_reg.month <= 7'd2) ? 15'sd1 : 15'sd0);
                doy_reg <= month_start(fd_reg.month) + 9'(fd_reg.day) - 9'd1;
                fr = fd_reg.frac;
                unique case (fd_reg.frac_digits)
                    3'd0: fr = 20'd0;
                    3'd1: fr = 20'(fr * 20'd100000);
                    3'd2: fr = 20'(fr * 20'd10000);
                    3'd3: fr = 20'(fr * 20'd1000);
                    3'd4: fr = 20'(fr * 20'd100);
                    3'd5: fr = 20'(fr * 20'd10);
                    default: fr = fr;
                endcase
                frac_reg <= fr;
                hms = signed'({1'b0, fd_reg.hour}) * 21'sd3600
                      + signed'({1'b0, fd_reg.minute}) * 21'sd60
                      + signed'({1'b0, fd_reg.second});
                off = signed'({1'b0, fd_reg.off_hours}) * 21'sd3600
                      + signed'({1'b0, fd_reg.off_mins}) * 21'sd60;
                lo_reg <= fd_reg.off_neg ? hms + off : hms - off;
            end
            CV_S2:
            begin
                // y / 400 by reciprocal, exact for 0..9999
                q = 28'(y_reg[13:0]) * 28'd5243;
                era_reg <= y_reg[14] ? -6'sd1 : signed'({1'b0, q[25:21]});
            end
            CV_S3:
            begin
                yoe_reg <= y_reg[14] ? 9'd399
                           : 9'(y_reg[13:0] - 14'(era_reg[4:0]) * 14'd400);
                base_reg <= 23'(era_reg) * 23'sd146097 - 23'sd719468;
            end
            CV_S4:
            begin
                cent = (yoe_reg >= 9'd300) ? 2'd3 : (yoe_reg >= 9'd200) ? 2'd2
                       : (yoe_reg >= 9'd100) ? 2'd1 : 2'd0;
                doe = 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2]) - 18'(cent) + 18'(doy_reg);
                days_reg <= base_reg + signed'({5'd0, doe});
            end
            CV_S5: secs_reg <= 41'(days_reg) * 41'sd86400 + 41'(lo_reg);
            CV_S6: us_reg <= fd_reg.ok ? 59'(secs_reg) * 59'sd1000000
                                         + signed'({39'd0, frac_reg}) : '0;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/iso8601_timestamp_parser.sv =====
`default_nettype none
// channel  dir  tdata                   tuser      tlast
// s_axis   in   [7:0] char_code         -          last_char
// m_axis   out  [58:0] epoch_micros     valid_res  -
// One character per cycle enters the parser front while the queue has room;
// each finished timestamp goes through a 2-entry queue to a conversion back
// end that steps through capture, six arithmetic stages and a result state.
// The back end holds each result until it is taken and only then accepts
// the next timestamp.
// Reset clears the parser and queue and idles the converter; either side may stall.
module iso8601_timestamp_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_code
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // epoch_micros, zero pad
    output logic             m_axis_tuser    // valid_res
);
    import itp_pkg::*;

    logic    f_valid, f_ready;
    fields_t f_data;

    itp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .char_code(s_axis_tdata), .last_char(s_axis_tlast),
        .f_valid(f_valid), .f_ready(f_ready), .f_data(f_data)
    );

    itp_back u_back (
        .clk(clk), .rst_n(rst_n),
        .f_valid(f_valid), .f_ready(f_ready), .f_data(f_data),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
        .m_tuser(m_axis_tuser)
    );

endmodule
`default_nettype wire
